// ===== design/prbe_pkg.sv =====
// prbe_pkg: shared widths, constants and the cell payload type for the
// partial-fraction basis evaluator. No dependencies.
`timescale 1ns / 1ps
package prbe_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_W          = 32;
  localparam int MAG_W         = IN_W + 1;
  localparam int SQ_W          = 2 * MAG_W;
  localparam int DEN_W         = SQ_W - 1;
  localparam int LIM_LOG       = 40;
  localparam int CQ_W          = LIM_LOG + 1;
  localparam int TERM_W        = CQ_W + 1;
  localparam int SUM_W         = TERM_W + 1;
  localparam int NTERM         = 4;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [DEN_W-1:0] den_t;

  typedef struct packed {
    logic                         valid;
    logic                         cplx;
    logic                         zero;
    logic                         sx;
    logic                         sy1;
    logic                         sy2;
    mag_t                         mx;
    mag_t                         my1;
    mag_t                         my2;
    den_t                         d1;
    den_t                         d2;
    logic [NTERM-1:0][DEN_W-1:0]  rem;
  } cell_t;

endpackage

// ===== design/prbe_pre.sv =====
// prbe_pre: forms signed offsets, their squares and the two denominators.
// Depends on prbe_pkg.
`timescale 1ns / 1ps
module prbe_pre
  import prbe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   operation,
  input  logic signed [IN_W-1:0] omega,
  input  logic signed [IN_W-1:0] pole_re,
  input  logic signed [IN_W-1:0] pole_im,
  output cell_t                  cell_out
);

  logic              v1, c1, sx1, sy11, sy21;
  mag_t              mx1, my11, my21;
  logic              v2, c2, sx2, sy12, sy22;
  mag_t              mx2, my12, my22;
  logic [SQ_W-1:0]   qx, qy1, qy2;
  logic [MAG_W:0]    x_s, y1_s, y2_s, pi_s;
  logic [MAG_W:0]    ax, ay1, ay2;
  logic [SQ_W-1:0]   s1, s2;
  cell_t             cell_next;

  always_comb begin
    pi_s = operation ? {{2{pole_im[IN_W-1]}}, pole_im} : '0;
    x_s  = -{{2{pole_re[IN_W-1]}}, pole_re};
    y1_s = {{2{omega[IN_W-1]}}, omega} - pi_s;
    y2_s = {{2{omega[IN_W-1]}}, omega} + pi_s;
    ax   = x_s[MAG_W] ? -x_s : x_s;
    ay1  = y1_s[MAG_W] ? -y1_s : y1_s;
    ay2  = y2_s[MAG_W] ? -y2_s : y2_s;
  end

  always_ff @(posedge clk) begin
    v1   <= rst ? 1'b0 : start;
    c1   <= operation;
    sx1  <= x_s[MAG_W];
    sy11 <= y1_s[MAG_W];
    sy21 <= y2_s[MAG_W];
    mx1  <= ax[MAG_W-1:0];
    my11 <= ay1[MAG_W-1:0];
    my21 <= ay2[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    v2   <= rst ? 1'b0 : v1;
    c2   <= c1;
    sx2  <= sx1;
    sy12 <= sy11;
    sy22 <= sy21;
    mx2  <= mx1;
    my12 <= my11;
    my22 <= my21;
    qx   <= SQ_W'(mx1) * SQ_W'(mx1);
    qy1  <= SQ_W'(my11) * SQ_W'(my11);
    qy2  <= SQ_W'(my21) * SQ_W'(my21);
  end

  always_comb begin
    s1              = qx + qy1;
    s2              = qx + qy2;
    cell_next.valid = v2 & ~rst;
    cell_next.cplx  = c2;
    cell_next.sx    = sx2;
    cell_next.sy1   = sy12;
    cell_next.sy2   = sy22;
    cell_next.mx    = mx2;
    cell_next.my1   = my12;
    cell_next.my2   = my22;
    cell_next.d1    = s1[DEN_W-1:0];
    cell_next.d2    = s2[DEN_W-1:0];
    cell_next.zero  = (s1 == '0) || (c2 && (s2 == '0));
    cell_next.rem   = '0;
  end

  always_ff @(posedge clk) begin
    cell_out <= cell_next;
  end

endmodule

// ===== design/prbe_cell.sv =====
// prbe_cell: one restoring-division step for all four quotients.
// Depends on prbe_pkg.
`timescale 1ns / 1ps
module prbe_cell
  import prbe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int QW        = MAG_W + 2 * FRAC_BITS,
  parameter int BIT       = 0
)
(
  input  logic                        clk,
  input  logic                        rst,
  input  cell_t                       cell_in,
  input  logic [NTERM-1:0][QW-1:0]    q_in,
  output cell_t                       cell_out,
  output logic [NTERM-1:0][QW-1:0]    q_out
);

  localparam int SEL = (BIT >= 2 * FRAC_BITS) ? BIT - 2 * FRAC_BITS : 0;
  localparam bit HAS = (BIT >= 2 * FRAC_BITS);

  logic [NTERM-1:0]            nb;
  logic [NTERM-1:0][DEN_W-1:0] dn;
  logic [NTERM-1:0][DEN_W:0]   sh, df;
  logic [NTERM-1:0]            ge;
  cell_t                       cell_next;
  logic [NTERM-1:0][QW-1:0]    q_next;

  always_comb begin
    nb[0] = HAS ? cell_in.mx[SEL]  : 1'b0;
    nb[1] = HAS ? cell_in.my1[SEL] : 1'b0;
    nb[2] = HAS ? cell_in.mx[SEL]  : 1'b0;
    nb[3] = HAS ? cell_in.my2[SEL] : 1'b0;
    dn[0] = cell_in.d1;
    dn[1] = cell_in.d1;
    dn[2] = cell_in.d2;
    dn[3] = cell_in.d2;
    cell_next = cell_in;
    cell_next.valid = cell_in.valid & ~rst;
    for (int k = 0; k < NTERM; k++) begin
      sh[k] = {cell_in.rem[k], nb[k]};
      ge[k] = sh[k] >= {1'b0, dn[k]};
      df[k] = sh[k] - {1'b0, dn[k]};
      cell_next.rem[k] = ge[k] ? df[k][DEN_W-1:0] : sh[k][DEN_W-1:0];
      q_next[k] = {q_in[k][QW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    cell_out <= cell_next;
    q_out    <= q_next;
  end

endmodule

// ===== design/prbe_post.sv =====
// prbe_post: clamps and signs the quotients, then sums and saturates; a zero flag forces saturation.
// Depends on prbe_pkg.
`timescale 1ns / 1ps
module prbe_post
  import prbe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int QW        = MAG_W + 2 * FRAC_BITS
)
(
  input  logic                       clk,
  input  logic                       rst,
  input  cell_t                      cell_in,
  input  logic [NTERM-1:0][QW-1:0]   q_in,
  output logic                       done,
  output logic signed [IN_W-1:0]     first_re,
  output logic signed [IN_W-1:0]     first_im,
  output logic signed [IN_W-1:0]     second_re,
  output logic signed [IN_W-1:0]     second_im,
  output logic                       saturated
);

  localparam logic [QW-1:0] LIM = QW'(1) << LIM_LOG;
  localparam logic signed [SUM_W-1:0] SMAX = SUM_W'((64'sd1 <<< (IN_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SMIN = -SUM_W'(64'sd1 <<< (IN_W - 1));
  localparam logic [IN_W-1:0] POS_MAX = {1'b0, {(IN_W - 1){1'b1}}};

  logic [NTERM-1:0]                    sg;
  logic [NTERM-1:0][CQ_W-1:0]          cq;
  logic signed [TERM_W-1:0]            t_next [NTERM];
  logic signed [TERM_W-1:0]            t [NTERM];
  logic                                v, c, z;
  logic signed [SUM_W-1:0]             e [NTERM];
  logic [NTERM-1:0]                    of;
  logic [NTERM-1:0][IN_W-1:0]          r;

  always_comb begin
    sg[0] = cell_in.sx;
    sg[1] = cell_in.sy1;
    sg[2] = cell_in.sx;
    sg[3] = cell_in.sy2;
    for (int k = 0; k < NTERM; k++) begin
      cq[k] = (q_in[k] > LIM) ? CQ_W'(LIM) : q_in[k][CQ_W-1:0];
      t_next[k] = sg[k] ? -$signed({1'b0, cq[k]}) : $signed({1'b0, cq[k]});
    end
  end

  always_ff @(posedge clk) begin
    v <= rst ? 1'b0 : cell_in.valid;
    c <= cell_in.cplx;
    z <= cell_in.zero;
    for (int k = 0; k < NTERM; k++) begin
      t[k] <= t_next[k];
    end
  end

  always_comb begin
    if (c) begin
      e[0] = SUM_W'(t[0]) + SUM_W'(t[2]);
      e[1] = -SUM_W'(t[1]) - SUM_W'(t[3]);
      e[2] = SUM_W'(t[1]) - SUM_W'(t[3]);
      e[3] = SUM_W'(t[0]) - SUM_W'(t[2]);
    end else begin
      e[0] = SUM_W'(t[0]);
      e[1] = -SUM_W'(t[1]);
      e[2] = '0;
      e[3] = '0;
    end
    for (int k = 0; k < NTERM; k++) begin
      of[k] = (e[k] > SMAX) || (e[k] < SMIN);
      if (e[k] > SMAX) begin
        r[k] = POS_MAX;
      end else if (e[k] < SMIN) begin
        r[k] = ~POS_MAX;
      end else begin
        r[k] = e[k][IN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    done <= rst ? 1'b0 : v;
    if (z) begin
      first_re  <= POS_MAX;
      first_im  <= POS_MAX;
      second_re <= c ? POS_MAX : '0;
      second_im <= c ? POS_MAX : '0;
      saturated <= 1'b1;
    end else begin
      first_re  <= r[0];
      first_im  <= r[1];
      second_re <= r[2];
      second_im <= r[3];
      saturated <= |of;
    end
  end

endmodule

// ===== design/pole_residue_basis_eval.sv =====
// Pipeline from start to done (FRAC_BITS of 16 gives Q16.16): prbe_pre registers the
// offsets, the squares and the denominators, one division cell per quotient bit
// follows, and prbe_post registers the clamp, then the sum and saturation.
// Throughput: one beat per cycle; busy is always low; the receiver cannot stall.
// Reset clears every valid flag in the chain; done stays low until a beat emerges.
`timescale 1ns / 1ps
module pole_residue_basis_eval
  import prbe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   operation,
  input  logic signed [IN_W-1:0] omega,
  input  logic signed [IN_W-1:0] pole_re,
  input  logic signed [IN_W-1:0] pole_im,
  output logic                   done,
  output logic signed [IN_W-1:0] first_re,
  output logic signed [IN_W-1:0] first_im,
  output logic signed [IN_W-1:0] second_re,
  output logic signed [IN_W-1:0] second_im,
  output logic                   saturated
);

  localparam int QW = MAG_W + 2 * FRAC_BITS;

  cell_t                     cc [QW+1];
  logic [NTERM-1:0][QW-1:0]  qc [QW+1];

  assign busy  = 1'b0;
  assign qc[0] = '0;

  prbe_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .omega     (omega),
    .pole_re   (pole_re),
    .pole_im   (pole_im),
    .cell_out  (cc[0])
  );

  for (genvar j = 0; j < QW; j++) begin : g_cell
    prbe_cell #(
      .FRAC_BITS (FRAC_BITS),
      .QW        (QW),
      .BIT       (QW - 1 - j)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_in  (cc[j]),
      .q_in     (qc[j]),
      .cell_out (cc[j+1]),
      .q_out    (qc[j+1])
    );
  end

  prbe_post #(
    .FRAC_BITS (FRAC_BITS),
    .QW        (QW)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .cell_in   (cc[QW]),
    .q_in      (qc[QW]),
    .done      (done),
    .first_re  (first_re),
    .first_im  (first_im),
    .second_re (second_re),
    .second_im (second_im),
    .saturated (saturated)
  );

endmodule
